// ===== sv/uuline_pkg.sv =====
// Package for the uudecode line block: status codes, the command word that
// travels from the character front end to the byte back end, and decode helpers.
// Depends on nothing; every other file refers to it by scoped names.
package uuline_pkg;

    localparam int MAX_LINE_BYTES_DEF = 45;
    localparam int CMD_DEPTH          = 4;

    localparam logic [7:0] CHAR_LO = 8'h20;
    localparam logic [7:0] CHAR_HI = 8'h60;

    typedef enum logic [1:0] {
        LS_DATA   = 2'd0,
        LS_CLOSE  = 2'd1,
        LS_REJECT = 2'd2
    } line_status_t;

    // One command per input item that has work for the back end. Clear comes
    // first, then the group write, then the end of line.
    typedef struct packed {
        logic         clear;
        logic         wr;
        logic [4:0]   wr_grp;
        logic [23:0]  wr_word;
        logic         fin;
        line_status_t status;
        logic [5:0]   count;
    } cmd_t;

    function automatic logic char_ok(input logic [7:0] ch);
        return (ch >= CHAR_LO) && (ch <= CHAR_HI);
    endfunction

    // Subtracting 0x20 modulo 64 only flips bit 5.
    function automatic logic [5:0] six_of(input logic [7:0] ch);
        return {~ch[5], ch[4:0]};
    endfunction

    // Data characters a count needs: four per started group of three bytes.
    // The group count is (count + 2) / 3, done as a multiply by 43 and a
    // shift by 7, which is exact for these operands.
    function automatic logic [6:0] needed_of(input logic [5:0] count);
        logic [6:0]  x;
        logic [12:0] p;
        x = {1'b0, count} + 7'd2;
        p = 13'(x) * 13'd43;
        return {p[11:7], 2'b00};
    endfunction

endpackage

// ===== sv/uudecode_line_block_top.sv =====
// Top level of the uudecode line block: front end, command queue and back end.
// Depends on uuline_pkg, uuline_front, uuline_cmd_fifo and uuline_back.
//
// The block decodes uuencoded data lines fed one character per transaction,
// with the line already trimmed. The first character of a line is the byte
// count; each later character from space to backquote carries six bits, four
// characters make three bytes, and a short line is padded with zeros. At the
// end of a line the block returns one transaction per decoded byte (last set
// on the final one), or a single transaction with byte_valid low and status
// "closing" for an empty or zero-count line, or status "rejected" for a bad
// count, a bad character, a line longer than its count, or data after the
// closing line. block_start begins a new block and drops any partial line.
// Both sides behave as queues: push/full on the input and empty/pop on the
// output. The front end takes one character per clock as long as its command
// queue (four entries by default) has room; every item that completes a group
// of four characters, starts a line or ends one places one command in it.
// While it is idle the back end retires one command per clock, except that a
// closing or rejected line waits for a free output register. For a data line
// it takes the end-of-line command, then for each group of three bytes reads
// the group store and emits the group's bytes one at a time, holding while a
// waiting result is not taken. The group store needs no clearing pass after
// reset: a valid bit per group, cleared at each count character, makes
// unwritten groups read as zero.
module uudecode_line_block_top #(
    parameter int MAX_LINE_BYTES = uuline_pkg::MAX_LINE_BYTES_DEF,
    parameter int CMD_DEPTH      = uuline_pkg::CMD_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       char_present,
    input  logic       end_of_line,
    input  logic       block_start,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       last,
    output logic [1:0] line_status
);

    uuline_pkg::cmd_t front_cmd;
    uuline_pkg::cmd_t back_cmd;
    logic             cmd_push;
    logic             cmd_pop;
    logic             fifo_full;
    logic             fifo_avail;

    // Front end: line parsing and group assembly.
    uuline_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .char_present (char_present),
        .end_of_line  (end_of_line),
        .block_start  (block_start),
        .fifo_full    (fifo_full),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    // Queue that lets the front end run ahead while a line drains.
    uuline_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (fifo_full),
        .rd_en   (cmd_pop),
        .avail   (fifo_avail),
        .rd_data (back_cmd)
    );

    // Back end: group store and result drain.
    uuline_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (fifo_avail),
        .cmd         (back_cmd),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .line_status (line_status)
    );

endmodule

// ===== sv/uuline_front.sv =====
// Front end of the uudecode line block: takes characters, tracks line state,
// and builds group words and end-of-line commands.
// Depends on uuline_pkg.
module uuline_front #(
    parameter int MAX_LINE_BYTES = uuline_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        char_code,
    input  logic              char_present,
    input  logic              end_of_line,
    input  logic              block_start,
    input  logic              fifo_full,
    output logic              cmd_push,
    output uuline_pkg::cmd_t  cmd
);

    localparam logic [5:0] MAX6 = 6'(MAX_LINE_BYTES);

    logic [5:0]  count_reg, count_next;
    logic [6:0]  needed_reg, needed_next;
    logic [6:0]  seen_reg, seen_next;
    logic [17:0] gbits_reg, gbits_next;
    logic [1:0]  gpos_reg, gpos_next;
    logic        bad_reg, bad_next;
    logic        closed_reg, closed_next;
    logic        at_start_reg, at_start_next;
    logic        accept;
    logic [5:0]  six;
    logic        six_ok;
    uuline_pkg::cmd_t cmd_v;

    assign accept = push && !fifo_full;
    assign full   = fifo_full;

    always_comb
    begin
        count_next    = count_reg;
        needed_next   = needed_reg;
        seen_next     = seen_reg;
        gbits_next    = gbits_reg;
        gpos_next     = gpos_reg;
        bad_next      = bad_reg;
        closed_next   = closed_reg;
        at_start_next = at_start_reg;
        cmd_v         = '0;
        cmd_v.status  = uuline_pkg::LS_DATA;
        six           = uuline_pkg::six_of(char_code);
        six_ok        = uuline_pkg::char_ok(char_code);

        if (block_start)
        begin
            closed_next   = 1'b0;
            at_start_next = 1'b1;
            count_next    = '0;
            needed_next   = '0;
            seen_next     = '0;
            gbits_next    = '0;
            gpos_next     = '0;
            bad_next      = 1'b0;
        end

        if (char_present)
        begin
            if (at_start_next)
            begin
                // Count character: a fresh line starts with no groups written.
                cmd_v.clear   = 1'b1;
                at_start_next = 1'b0;
                seen_next     = '0;
                gbits_next    = '0;
                gpos_next     = '0;
                if (!six_ok || (six > MAX6))
                begin
                    bad_next   = 1'b1;
                    count_next = '0;
                end
                else
                begin
                    bad_next   = 1'b0;
                    count_next = six;
                end
                needed_next = uuline_pkg::needed_of(count_next);
            end
            else
            begin
                if ((seen_next >= needed_next) || !six_ok)
                begin
                    bad_next = 1'b1;
                end
                if (!bad_next)
                begin
                    if (gpos_next == 2'd3)
                    begin
                        cmd_v.wr      = 1'b1;
                        cmd_v.wr_grp  = seen_next[6:2];
                        cmd_v.wr_word = {gbits_next, six};
                        gbits_next    = '0;
                        gpos_next     = '0;
                    end
                    else
                    begin
                        gbits_next = {gbits_next[11:0], six};
                        gpos_next  = gpos_next + 2'd1;
                    end
                end
                if (seen_next != 7'h7F)
                begin
                    seen_next = seen_next + 7'd1;
                end
            end
        end

        if (end_of_line)
        begin
            cmd_v.fin = 1'b1;
            if (at_start_next)
            begin
                cmd_v.status = uuline_pkg::LS_CLOSE;
                closed_next  = 1'b1;
            end
            else if (closed_next || bad_next)
            begin
                cmd_v.status = uuline_pkg::LS_REJECT;
            end
            else
            begin
                // A short final group is padded with zero characters.
                if (gpos_next != 2'd0)
                begin
                    cmd_v.wr     = 1'b1;
                    cmd_v.wr_grp = seen_next[6:2];
                    case (gpos_next)
                        2'd1:    cmd_v.wr_word = {gbits_next[5:0], 18'd0};
                        2'd2:    cmd_v.wr_word = {gbits_next[11:0], 12'd0};
                        default: cmd_v.wr_word = {gbits_next, 6'd0};
                    endcase
                end
                if (count_next == 6'd0)
                begin
                    cmd_v.status = uuline_pkg::LS_CLOSE;
                    closed_next  = 1'b1;
                end
                else
                begin
                    cmd_v.count = count_next;
                end
            end
            at_start_next = 1'b1;
            count_next    = '0;
            needed_next   = '0;
            seen_next     = '0;
            gbits_next    = '0;
            gpos_next     = '0;
            bad_next      = 1'b0;
        end
    end

    assign cmd      = cmd_v;
    assign cmd_push = accept && (cmd_v.clear || cmd_v.wr || cmd_v.fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            needed_reg   <= '0;
            seen_reg     <= '0;
            gbits_reg    <= '0;
            gpos_reg     <= '0;
            bad_reg      <= 1'b0;
            closed_reg   <= 1'b0;
            at_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            count_reg    <= count_next;
            needed_reg   <= needed_next;
            seen_reg     <= seen_next;
            gbits_reg    <= gbits_next;
            gpos_reg     <= gpos_next;
            bad_reg      <= bad_next;
            closed_reg   <= closed_next;
            at_start_reg <= at_start_next;
        end
    end

endmodule

// ===== sv/uuline_cmd_fifo.sv =====
// Command queue between the front and back ends of the uudecode line block.
// Depends on uuline_pkg for the command type.
module uuline_cmd_fifo #(
    parameter int DEPTH = uuline_pkg::CMD_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  uuline_pkg::cmd_t  wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              avail,
    output uuline_pkg::cmd_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uuline_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign avail   = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/uuline_back.sv =====
// Back end of the uudecode line block: holds the decoded groups of the line
// and drains them as result bytes through a one-entry output register.
// Depends on uuline_pkg.
module uuline_back #(
    parameter int MAX_LINE_BYTES = uuline_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_avail,
    input  uuline_pkg::cmd_t          cmd,
    output logic                      cmd_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [7:0]                data_byte,
    output logic                      byte_valid,
    output logic                      last,
    output logic [1:0]                line_status
);

    localparam int GROUPS = (MAX_LINE_BYTES + 2) / 3;
    localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_READ = 3'b010,
        BK_EMIT = 3'b100
    } bk_state_t;

    bk_state_t               state_reg, state_next;
    logic [GIDX_W-1:0]       grp_reg, grp_next;
    logic [1:0]              lane_reg, lane_next;
    logic [5:0]              left_reg, left_next;
    logic [23:0]             mem_reg [GROUPS];
    logic [GROUPS-1:0]       gvalid_reg;
    logic [23:0]             rd_word_reg;
    logic                    rd_ok_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_byte_reg;
    logic                    out_bvalid_reg;
    logic                    out_last_reg;
    uuline_pkg::line_status_t out_status_reg;
    logic                    load_ok;
    logic                    out_load;
    logic [7:0]              ld_byte;
    logic                    ld_bvalid;
    logic                    ld_last;
    uuline_pkg::line_status_t ld_status;
    logic [7:0]              lane_byte;

    assign load_ok = !out_valid_reg || pop;

    always_comb
    begin
        case (lane_reg)
            2'd0:    lane_byte = rd_word_reg[23:16];
            2'd1:    lane_byte = rd_word_reg[15:8];
            default: lane_byte = rd_word_reg[7:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        grp_next   = grp_reg;
        lane_next  = lane_reg;
        left_next  = left_reg;
        cmd_pop    = 1'b0;
        out_load   = 1'b0;
        ld_byte    = '0;
        ld_bvalid  = 1'b0;
        ld_last    = 1'b1;
        ld_status  = uuline_pkg::LS_DATA;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_avail)
                begin
                    if (cmd.fin && (cmd.status != uuline_pkg::LS_DATA))
                    begin
                        // Closing or rejected line: one result, no bytes.
                        if (load_ok)
                        begin
                            cmd_pop   = 1'b1;
                            out_load  = 1'b1;
                            ld_status = cmd.status;
                        end
                    end
                    else
                    begin
                        cmd_pop = 1'b1;
                        if (cmd.fin)
                        begin
                            left_next  = cmd.count;
                            grp_next   = '0;
                            lane_next  = '0;
                            state_next = BK_READ;
                        end
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (load_ok)
                begin
                    out_load  = 1'b1;
                    ld_byte   = rd_ok_reg ? lane_byte : 8'd0;
                    ld_bvalid = 1'b1;
                    ld_last   = (left_reg == 6'd1);
                    left_next = left_reg - 6'd1;
                    if (left_reg == 6'd1)
                    begin
                        state_next = BK_IDLE;
                    end
                    else if (lane_reg == 2'd2)
                    begin
                        lane_next  = '0;
                        grp_next   = grp_reg + 1'b1;
                        state_next = BK_READ;
                    end
                    else
                    begin
                        lane_next = lane_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Group store: one row per group of three bytes, one write port and one
    // registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.wr)
        begin
            mem_reg[cmd.wr_grp[GIDX_W-1:0]] <= cmd.wr_word;
        end
        if (state_reg == BK_READ)
        begin
            rd_word_reg <= mem_reg[grp_reg];
            rd_ok_reg   <= gvalid_reg[grp_reg];
        end
        if (out_load)
        begin
            out_byte_reg   <= ld_byte;
            out_bvalid_reg <= ld_bvalid;
            out_last_reg   <= ld_last;
            out_status_reg <= ld_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            grp_reg       <= '0;
            lane_reg      <= '0;
            left_reg      <= '0;
            gvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            lane_reg  <= lane_next;
            left_reg  <= left_next;
            if (cmd_pop)
            begin
                // Rows not written since the count character read as zero.
                if (cmd.clear && cmd.wr)
                begin
                    gvalid_reg <= GROUPS'(1) << cmd.wr_grp[GIDX_W-1:0];
                end
                else if (cmd.clear)
                begin
                    gvalid_reg <= '0;
                end
                else if (cmd.wr)
                begin
                    gvalid_reg[cmd.wr_grp[GIDX_W-1:0]] <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign data_byte   = out_byte_reg;
    assign byte_valid  = out_bvalid_reg;
    assign last        = out_last_reg;
    assign line_status = out_status_reg;

endmodule

// ===== sv/uuline_checker.sv =====
// Port-level checks for the uudecode line block and the bind that attaches
// them to the top level. Depends on uuline_pkg and uudecode_line_block_top.
module uuline_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       last,
    input logic [1:0] line_status
);

    // A waiting result that is not taken stays as it is.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(data_byte) && $stable(byte_valid)
            && $stable(last) && $stable(line_status))
        else $error("result changed while waiting");

    // A result without a byte closes or rejects a line and ends it.
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !byte_valid |-> last && (data_byte == 8'd0)
            && (line_status != uuline_pkg::LS_DATA))
        else $error("byte-less result is malformed");

    // Decoded bytes belong to data lines only.
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && byte_valid |-> (line_status == uuline_pkg::LS_DATA))
        else $error("decoded byte with non-data status");

    // Only data bytes can be followed by more results of the same line.
    a_notlast: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !last |-> byte_valid)
        else $error("non-final result without a byte");

endmodule

bind uudecode_line_block_top uuline_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .line_status (line_status)
);
